// ===== design/kedf_pkg.sv =====
// ----------------------------------------------------------------------------
// kedf_pkg
// Types, register indexes, reset values and character constants shared by
// the key event decoder and its character FIFO.
// ----------------------------------------------------------------------------
package kedf_pkg;

    localparam int unsigned CfgWidth       = 8;
    localparam int unsigned CfgIndexWidth  = 3;
    localparam int unsigned DefFifoDepth   = 16;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_STATE_PRESSED  = 3'd0,
        CFG_STATE_RELEASED = 3'd1,
        CFG_CTRL_KEY       = 3'd2,
        CFG_LEFT_SHIFT     = 3'd3,
        CFG_RIGHT_SHIFT    = 3'd4,
        CFG_ALT_KEY        = 3'd5,
        CFG_BREAK_KEY      = 3'd6
    } t_cfg_index;

    localparam logic [7:0] RstStatePressed  = 8'd1;
    localparam logic [7:0] RstStateReleased = 8'd3;
    localparam logic [7:0] RstCtrlKey       = 8'd165;
    localparam logic [7:0] RstLeftShift     = 8'd162;
    localparam logic [7:0] RstRightShift    = 8'd163;
    localparam logic [7:0] RstAltKey        = 8'd161;
    localparam logic [7:0] RstBreakKey      = 8'd208;

    localparam logic [7:0] CharLowerA = 8'h61;
    localparam logic [7:0] CharLowerZ = 8'h7A;
    localparam logic [7:0] CtrlMask   = 8'hBF;
    localparam logic [7:0] ShiftMask  = 8'hDF;
    localparam logic [7:0] CharLf     = 8'h0A;
    localparam logic [7:0] CharCr     = 8'h0D;
    localparam logic [7:0] NoEvent    = 8'h00;

    typedef struct packed {
        logic [7:0] state_pressed;
        logic [7:0] state_released;
        logic [7:0] ctrl_key;
        logic [7:0] left_shift;
        logic [7:0] right_shift;
        logic [7:0] alt_key;
        logic [7:0] break_key;
    } t_cfg;

    typedef struct packed {
        logic       char_valid;
        logic       chars_available;
        logic       break_pulse;
        logic       overflow;
        logic [2:0] modifiers;
    } t_step_info;

    function automatic logic [7:0] map_char(
        input logic [7:0] code,
        input logic       ctrl,
        input logic       shift
    );
        logic [7:0] ch;
        ch = code;
        if (code >= CharLowerA && code <= CharLowerZ) begin
            if (ctrl) begin
                ch = ch & CtrlMask;
            end
            if (shift) begin
                ch = ch & ShiftMask;
            end
        end
        if (ch == CharLf) begin
            ch = CharCr;
        end
        return ch;
    endfunction

endpackage

// ===== design/key_event_decoder_fifo.sv =====
// ----------------------------------------------------------------------------
// key_event_decoder_fifo
// Keyboard event decoder with modifier tracking and a ring character FIFO.
//
//   channel  valid        stall        payload
//   in       i_in_valid   o_in_stall   i_func, i_event_state, i_event_code
//   out      o_out_valid  i_out_stall  o_char_valid, o_char_out,
//                                      o_chars_available, o_break_pulse,
//                                      o_overflow, o_modifiers
//   cfg      i_cfg_wr_en  -            i_cfg_index, i_cfg_wdata
//
// One transaction per cycle while o_in_stall is low; results pass through the
// store read stage and the output register. Pointers and modifiers update at
// the accept edge; popped data returns from the store in the following cycle.
// Synchronous active-low reset clears pointers, flags and valids; no clearing
// pass over the store.
// The input stalls only when both the read stage and the output register hold
// a transaction and the output is stalled.
// ----------------------------------------------------------------------------
module key_event_decoder_fifo #(
    parameter int unsigned FIFO_DEPTH = kedf_pkg::DefFifoDepth
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [kedf_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  logic [kedf_pkg::CfgWidth-1:0]      i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_func,
    input  logic [7:0]                         i_event_state,
    input  logic [7:0]                         i_event_code,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_char_valid,
    output logic [7:0]                         o_char_out,
    output logic                               o_chars_available,
    output logic                               o_break_pulse,
    output logic                               o_overflow,
    output logic [2:0]                         o_modifiers
);
    import kedf_pkg::*;

    localparam int unsigned AW = $clog2(FIFO_DEPTH);

    t_cfg          r_cfg;
    logic          accept;
    logic          mem_wr_en, mem_rd_en;
    logic [AW-1:0] mem_wr_addr, mem_rd_addr;
    logic [7:0]    mem_wr_data, mem_rd_data;
    t_step_info    step_info;

    logic          r_s1_valid, n_s1_valid;
    t_step_info    r_s1_info;
    logic          s1_move;
    logic          r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.state_pressed  <= RstStatePressed;
            r_cfg.state_released <= RstStateReleased;
            r_cfg.ctrl_key       <= RstCtrlKey;
            r_cfg.left_shift     <= RstLeftShift;
            r_cfg.right_shift    <= RstRightShift;
            r_cfg.alt_key        <= RstAltKey;
            r_cfg.break_key      <= RstBreakKey;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_STATE_PRESSED:  r_cfg.state_pressed  <= i_cfg_wdata;
                CFG_STATE_RELEASED: r_cfg.state_released <= i_cfg_wdata;
                CFG_CTRL_KEY:       r_cfg.ctrl_key       <= i_cfg_wdata;
                CFG_LEFT_SHIFT:     r_cfg.left_shift     <= i_cfg_wdata;
                CFG_RIGHT_SHIFT:    r_cfg.right_shift    <= i_cfg_wdata;
                CFG_ALT_KEY:        r_cfg.alt_key        <= i_cfg_wdata;
                CFG_BREAK_KEY:      r_cfg.break_key      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = r_s1_valid && r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);

    kedf_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_func        (i_func),
        .i_event_state (i_event_state),
        .i_event_code  (i_event_code),
        .i_cfg         (r_cfg),
        .o_wr_en       (mem_wr_en),
        .o_wr_addr     (mem_wr_addr),
        .o_wr_data     (mem_wr_data),
        .o_rd_en       (mem_rd_en),
        .o_rd_addr     (mem_rd_addr),
        .o_info        (step_info)
    );

    kedf_char_mem #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .AW         (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_move) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (s1_move) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info <= step_info;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            o_char_valid      <= r_s1_info.char_valid;
            o_char_out        <= r_s1_info.char_valid ? mem_rd_data : 8'h00;
            o_chars_available <= r_s1_info.chars_available;
            o_break_pulse     <= r_s1_info.break_pulse;
            o_overflow        <= r_s1_info.overflow;
            o_modifiers       <= r_s1_info.modifiers;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== design/kedf_char_mem.sv =====
// ----------------------------------------------------------------------------
// kedf_char_mem
// Character store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kedf_char_mem #(
    parameter int unsigned FIFO_DEPTH = kedf_pkg::DefFifoDepth,
    parameter int unsigned AW         = $clog2(FIFO_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [FIFO_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/kedf_ctrl.sv =====
// ----------------------------------------------------------------------------
// kedf_ctrl
// Event decode, modifier flags and FIFO pointers; issues store accesses.
// ----------------------------------------------------------------------------
module kedf_ctrl #(
    parameter int unsigned FIFO_DEPTH = kedf_pkg::DefFifoDepth,
    parameter int unsigned AW         = $clog2(FIFO_DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_func,
    input  logic [7:0]             i_event_state,
    input  logic [7:0]             i_event_code,
    input  kedf_pkg::t_cfg         i_cfg,
    output logic                   o_wr_en,
    output logic [AW-1:0]          o_wr_addr,
    output logic [7:0]             o_wr_data,
    output logic                   o_rd_en,
    output logic [AW-1:0]          o_rd_addr,
    output kedf_pkg::t_step_info   o_info
);
    import kedf_pkg::*;

    localparam logic [AW-1:0] LastIdx = AW'(FIFO_DEPTH - 1);

    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic          r_ctrl, n_ctrl;
    logic          r_shift, n_shift;
    logic          r_alt, n_alt;

    logic          is_event, pressed, released;
    logic          is_ctrl, is_shift, is_alt, is_brk;
    logic          push_req, full, empty, do_push, do_pop;
    logic [AW-1:0] wr_adv, rd_adv;

    always_comb begin
        is_event = !i_func && (i_event_state != NoEvent);
        pressed  = is_event && (i_event_state == i_cfg.state_pressed);
        released = is_event && !pressed && (i_event_state == i_cfg.state_released);
        is_ctrl  = (i_event_code == i_cfg.ctrl_key);
        is_shift = (i_event_code == i_cfg.left_shift) || (i_event_code == i_cfg.right_shift);
        is_alt   = (i_event_code == i_cfg.alt_key);
        is_brk   = (i_event_code == i_cfg.break_key);

        wr_adv = (r_wr_idx == LastIdx) ? '0 : r_wr_idx + 1'b1;
        rd_adv = (r_rd_idx == LastIdx) ? '0 : r_rd_idx + 1'b1;
        empty  = (r_wr_idx == r_rd_idx);
        full   = (wr_adv == r_rd_idx);

        push_req = i_accept && released && !is_ctrl && !is_shift && !is_alt;
        do_push  = push_req && !full;
        do_pop   = i_accept && i_func && !empty;

        n_ctrl  = r_ctrl;
        n_shift = r_shift;
        n_alt   = r_alt;
        if (i_accept && (pressed || released)) begin
            if (is_ctrl) begin
                n_ctrl = pressed;
            end else if (is_shift) begin
                n_shift = pressed;
            end else if (is_alt) begin
                n_alt = pressed;
            end
        end

        n_wr_idx = do_push ? wr_adv : r_wr_idx;
        n_rd_idx = do_pop ? rd_adv : r_rd_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_ctrl   <= 1'b0;
            r_shift  <= 1'b0;
            r_alt    <= 1'b0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_ctrl   <= n_ctrl;
            r_shift  <= n_shift;
            r_alt    <= n_alt;
        end
    end

    always_comb begin
        o_wr_en   = do_push;
        o_wr_addr = r_wr_idx;
        o_wr_data = map_char(i_event_code, r_ctrl, r_shift);
        o_rd_en   = do_pop;
        o_rd_addr = r_rd_idx;

        o_info.char_valid      = do_pop;
        o_info.chars_available = (n_wr_idx != n_rd_idx);
        o_info.break_pulse     = pressed && !is_ctrl && !is_shift && !is_alt && is_brk;
        o_info.overflow        = push_req && full;
        o_info.modifiers       = {n_alt, n_shift, n_ctrl};
    end

endmodule
